### hdl/varint_length_prefix_decoder_top_macros.svh
// Assertion helpers for the varint decoder. Each use sits on its own line.
`ifndef VARINT_LENGTH_PREFIX_DECODER_TOP_MACROS_SVH
`define VARINT_LENGTH_PREFIX_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define VLPD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define VLPD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### hdl/vlpd_pkg.sv
package vlpd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned LengthW = 5;
  localparam int unsigned ZeroCntW = 3;
  localparam logic [LengthW-1:0] LengthMax = '1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PREFIX = 2'd1,
    ST_LOST   = 2'd2
  } status_e;

  typedef struct packed {
    logic [ValueW-1:0]  decoded_value;
    logic [LengthW-1:0] code_len;
    status_e            status;
  } result_t;

  // Position of the highest set bit; 0 for a zero byte
  function automatic logic [2:0] top_bit(input logic [ByteW-1:0] b);
    logic [2:0] p;
    p = '0;
    for (int i = 0; i < ByteW; i++) begin
      if (b[i]) p = 3'(i);
    end
    return p;
  endfunction

  // Bits of a byte below position p
  function automatic logic [ByteW-1:0] low_mask(input logic [2:0] p);
    return 8'((9'd1 << p) - 9'd1);
  endfunction

endpackage

### hdl/vlpd_if.sv
// Input channel: one code byte per item
interface vlpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

// Output channel: one decoded code per item
interface vlpd_out_if;
  logic                   valid;
  logic                   ready;
  logic [63:0]            decoded_value;
  logic [4:0]             code_len;
  vlpd_pkg::status_e      status;

  modport source (output valid, output decoded_value, output code_len,
                  output status, input ready);
  modport sink   (input valid, input decoded_value, input code_len,
                  input status, output ready);
endinterface

### hdl/vlpd_in_reg.sv
module vlpd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       pop_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);
  import vlpd_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             load;

  // Refill when empty or when the held item leaves this cycle
  assign ready_o = !valid_q || pop_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### hdl/vlpd_step.sv
module vlpd_step #(
  parameter int unsigned MAX_ZERO_BYTES = 1,
  parameter int unsigned VALUE_BITS     = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        byte_i,
  input  logic              slot_free_i,
  output logic              take_o,
  output logic              res_valid_o,
  output vlpd_pkg::result_t res_o
);
  import vlpd_pkg::*;

  localparam int unsigned RemW = $clog2(8 + 7 * MAX_ZERO_BYTES);

  logic                  phase_q, phase_d;
  logic [ZeroCntW-1:0]   zcnt_q, zcnt_d;
  logic [RemW-1:0]       rem_q, rem_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [LengthW-1:0]    cnt_q, cnt_d;
  logic                  lost_q, lost_d;

  logic [LengthW-1:0]    cnt_inc;
  logic [2:0]            pos;
  logic [VALUE_BITS+7:0] shifted;
  logic                  emit;
  logic                  emit_prefix;
  logic                  restart;

  assign take_o  = valid_i && slot_free_i;
  assign cnt_inc = (cnt_q == LengthMax) ? cnt_q : cnt_q + 1'b1;
  assign pos     = top_bit(byte_i);
  assign shifted = {acc_q, byte_i};

  // Advance the decode state by one byte
  always_comb begin
    phase_d     = phase_q;
    zcnt_d      = zcnt_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    cnt_d       = cnt_inc;
    lost_d      = lost_q;
    emit        = 1'b0;
    emit_prefix = 1'b0;
    if (!phase_q) begin
      if (byte_i == '0) begin
        if (zcnt_q >= ZeroCntW'(MAX_ZERO_BYTES)) begin
          emit_prefix = 1'b1;
        end else begin
          zcnt_d = zcnt_q + 1'b1;
        end
      end else begin
        acc_d   = VALUE_BITS'(byte_i & low_mask(pos));
        rem_d   = RemW'(3'd7 - pos) + RemW'(({3'b000, zcnt_q} << 3) - {3'b000, zcnt_q});
        phase_d = 1'b1;
        emit    = (rem_d == '0);
      end
    end else begin
      if (acc_q[VALUE_BITS-1 -: ByteW] != '0) begin
        lost_d = 1'b1;
      end
      acc_d = shifted[VALUE_BITS-1:0];
      if (rem_q != '0) begin
        rem_d = rem_q - 1'b1;
      end
      emit = (rem_d == '0);
    end
  end

  assign restart     = emit || emit_prefix;
  assign res_valid_o = restart;

  // Shape the result item
  always_comb begin
    res_o.code_len = cnt_inc;
    if (emit_prefix) begin
      res_o.decoded_value = '0;
      res_o.status        = ST_PREFIX;
    end else begin
      res_o.decoded_value = ValueW'(acc_d);
      res_o.status        = lost_d ? ST_LOST : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      zcnt_q  <= '0;
      rem_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      lost_q  <= 1'b0;
    end else if (take_o) begin
      if (restart) begin
        phase_q <= 1'b0;
        zcnt_q  <= '0;
        rem_q   <= '0;
        acc_q   <= '0;
        cnt_q   <= '0;
        lost_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        zcnt_q  <= zcnt_d;
        rem_q   <= rem_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        lost_q  <= lost_d;
      end
    end
  end

endmodule

### hdl/vlpd_out_reg.sv
module vlpd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  vlpd_pkg::result_t res_i,
  input  logic              ready_i,
  output logic              slot_free_o,
  output logic              valid_o,
  output vlpd_pkg::result_t res_o
);
  import vlpd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Slot opens when empty or drained this cycle
  assign slot_free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### hdl/varint_length_prefix_decoder_top.sv
// Length-prefixed varint decoder. Takes one code byte per item and returns one
// item per complete code: the value (low VALUE_BITS bits, zero-extended to 64),
// the byte count of the code saturated at 31, and a status (ok, zero prefix
// longer than MAX_ZERO_BYTES, or bits lost above VALUE_BITS). Rate is one byte
// per cycle, sustained as long as the output side keeps up. An accepted byte
// passes through the input register, then through the single decode step into
// the result register. The step updates the per-code state once per byte, which
// is what sets the one-byte figure.
module varint_length_prefix_decoder_top #(
  parameter int unsigned MAX_ZERO_BYTES = 1,
  parameter int unsigned VALUE_BITS     = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  vlpd_in_if.sink          in_i,
  vlpd_out_if.source       out_o
);
  import vlpd_pkg::*;

  logic       step_valid;
  logic [7:0] step_byte;
  logic       take;
  logic       slot_free;
  logic       res_valid;
  result_t    res;
  result_t    res_q;

  // Hold the incoming byte
  vlpd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .byte_i  (in_i.code_byte),
    .pop_i   (take),
    .valid_o (step_valid),
    .byte_o  (step_byte)
  );

  // Decode one byte against the running code state
  vlpd_step #(
    .MAX_ZERO_BYTES (MAX_ZERO_BYTES),
    .VALUE_BITS     (VALUE_BITS)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (step_valid),
    .byte_i      (step_byte),
    .slot_free_i (slot_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold the finished result until taken
  vlpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && res_valid),
    .res_i       (res),
    .ready_i     (out_o.ready),
    .slot_free_o (slot_free),
    .valid_o     (out_o.valid),
    .res_o       (res_q)
  );

  assign out_o.decoded_value = res_q.decoded_value;
  assign out_o.code_len      = res_q.code_len;
  assign out_o.status        = res_q.status;

`include "varint_length_prefix_decoder_top_macros.svh"

  `VLPD_ASSERT_IMP(a_len_nonzero, clk_i, rst_ni, out_o.valid, out_o.code_len != '0)
  `VLPD_ASSERT_IMP(a_prefix_zero, clk_i, rst_ni, out_o.valid && (out_o.status == ST_PREFIX), out_o.decoded_value == '0)
  `VLPD_ASSERT_NXT(a_in_hold, clk_i, rst_ni, step_valid && !take, step_valid && $stable(step_byte))
  `VLPD_ASSERT_IMP(a_take_has_slot, clk_i, rst_ni, take, step_valid && (!out_o.valid || out_o.ready))

endmodule
